// ===== rtl/fpc_pkg.sv =====
// fpc_pkg: shared types, codes and fixed-point helpers for frustum plane culling
// no dependencies
package fpc_pkg;

  localparam int FracBits   = 16;
  localparam int PlaneCount = 6;
  localparam int Row3Base   = 12;
  localparam int SqrtSteps  = 32;
  localparam int DivSteps   = 64;

  typedef enum logic [2:0] {
    ACT_LOAD_PROJ = 3'd0,
    ACT_LOAD_VIEW = 3'd1,
    ACT_EXTRACT   = 3'd2,
    ACT_POINT     = 3'd3,
    ACT_SPHERE    = 3'd4
  } action_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load_item;
    logic       wr_proj;
    logic       wr_view;
    logic       mac_clear;
    logic       mac_step;
    logic       clip_store;
    logic       raw_form;
    logic       nsq_step;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       div_start;
    logic       div_step;
    logic       coef_store;
    logic       degen_clear;
    logic       dist_step;
    logic       dist_eval;
    logic       res_clear;
    logic       res_finish;
    logic [3:0] clip_idx;
    logic [1:0] k_idx;
    logic [2:0] plane_idx;
    logic [1:0] j_idx;
  } fpc_cmd_t;

  typedef struct packed {
    logic culled;
  } fpc_sts_t;

  // plane p uses row plane_row and adds (1) or subtracts (0) it from row 3
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    return p[2:1];
  endfunction

  function automatic logic plane_add(input logic [2:0] p);
    return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/fpc_ctrl.sv =====
// fpc_ctrl: sequencer for loads, plane extraction and queries
// depends on fpc_pkg
module fpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        action_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fpc_pkg::fpc_sts_t sts_i,
  output fpc_pkg::fpc_cmd_t cmd_o
);
  import fpc_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DEC   = 10'b0000000010,
    ST_MAC   = 10'b0000000100,
    ST_RAW   = 10'b0000001000,
    ST_NSQ   = 10'b0000010000,
    ST_SQRT  = 10'b0000100000,
    ST_DIV   = 10'b0001000000,
    ST_DIST  = 10'b0010000000,
    ST_EVAL  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] act_q, act_d;
  logic [3:0] clip_q, clip_d;
  logic [1:0] k_q, k_d;
  logic [2:0] p_q, p_d;
  logic [1:0] j_q, j_d;
  logic [6:0] cnt_q, cnt_d;

  assign in_ready_o  = (state_q == ST_IDLE) ||
                       ((state_q == ST_OUT) && out_ready_i);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    clip_d  = clip_q;
    k_d     = k_q;
    p_d     = p_q;
    j_d     = j_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.clip_idx  = clip_q;
    cmd_o.k_idx     = k_q;
    cmd_o.plane_idx = p_q;
    cmd_o.j_idx     = j_q;
    unique case (state_q)
      ST_IDLE, ST_OUT: begin
        if (state_q == ST_IDLE || out_ready_i) state_d = ST_IDLE;
        if (in_valid_i && in_ready_o) begin
          cmd_o.load_item = 1'b1;
          act_d   = action_i;
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        clip_d = '0; k_d = '0; p_d = '0; j_d = '0; cnt_d = '0;
        cmd_o.res_clear = 1'b1;
        case (act_q)
          ACT_LOAD_PROJ: begin cmd_o.wr_proj = 1'b1; state_d = ST_OUT; end
          ACT_LOAD_VIEW: begin cmd_o.wr_view = 1'b1; state_d = ST_OUT; end
          ACT_EXTRACT: begin
            cmd_o.mac_clear   = 1'b1;
            cmd_o.degen_clear = 1'b1;
            state_d = ST_MAC;
          end
          ACT_POINT, ACT_SPHERE: state_d = ST_DIST;
          default: state_d = ST_OUT;
        endcase
      end
      ST_MAC: begin
        cmd_o.mac_step = 1'b1;
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          cmd_o.clip_store = 1'b1;
          clip_d = clip_q + 4'd1;
          if (clip_q == 4'd15) state_d = ST_RAW;
        end
      end
      ST_RAW: begin
        cmd_o.raw_form = 1'b1;
        j_d = '0;
        state_d = ST_NSQ;
      end
      ST_NSQ: begin
        cmd_o.nsq_step = 1'b1;
        j_d = j_q + 2'd1;
        if (j_q == 2'd2) begin
          cmd_o.sqrt_start = 1'b1;
          cnt_d = '0;
          j_d = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(SqrtSteps - 1)) begin
          cnt_d = '0; j_d = '0;
          state_d = ST_DIV;
          cmd_o.div_start = 1'b1;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps)) begin
          cmd_o.div_step   = 1'b0;
          cmd_o.coef_store = 1'b1;
          cnt_d = '0;
          j_d = j_q + 2'd1;
          if (j_q == 2'd3) begin
            p_d = p_q + 3'd1;
            state_d = (p_q == 3'(PlaneCount - 1)) ? ST_OUT : ST_RAW;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end
      end
      ST_DIST: begin
        cmd_o.dist_step = 1'b1;
        j_d = j_q + 2'd1;
        if (j_q == 2'd3) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.dist_eval = 1'b1;
        j_d = '0;
        p_d = p_q + 3'd1;
        if (sts_i.culled || p_q == 3'(PlaneCount - 1)) begin
          cmd_o.res_finish = 1'b1;
          state_d = ST_OUT;
        end else begin
          state_d = ST_DIST;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      act_q   <= '0;
      clip_q  <= '0;
      k_q     <= '0;
      p_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
      clip_q  <= clip_d;
      k_q     <= k_d;
      p_q     <= p_d;
      j_q     <= j_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/fpc_dp.sv =====
// fpc_dp: matrix stores, shared multiplier, square root and divider, plane store
// depends on fpc_pkg
module fpc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpc_pkg::fpc_cmd_t   cmd_i,
  output fpc_pkg::fpc_sts_t   sts_o,
  input  logic [2:0]          action_i,
  input  logic [3:0]          elem_index_i,
  input  logic signed [31:0]  elem_value_i,
  input  logic signed [31:0]  point_x_i,
  input  logic signed [31:0]  point_y_i,
  input  logic signed [31:0]  point_z_i,
  input  logic [30:0]         sphere_radius_i,
  output logic                inside_res_o,
  output logic signed [31:0]  near_distance_o,
  output logic                plane_degenerate_o
);
  import fpc_pkg::*;

  logic signed [31:0] proj_q [16];
  logic signed [31:0] view_q [16];
  logic signed [31:0] clip_q [16];
  logic signed [31:0] coef_q [24];
  logic signed [31:0] raw_q  [4];
  logic               degen_q;

  logic [2:0]         act_q;
  logic [3:0]         idx_q;
  logic signed [31:0] val_q, x_q, y_q, z_q;
  logic [30:0]        rad_q;

  logic signed [65:0] acc_q;
  logic [63:0]        nsq_q;
  logic [63:0]        srem_q, sroot_q, sbit_q;
  logic [31:0]        len_q;
  logic [63:0]        dnum_q, dquo_q;
  logic [32:0]        drem_q;
  logic               dneg_q;
  logic signed [66:0] dist_q;
  logic               inside_q;
  logic signed [31:0] near_q;

  // shared multiplier: operands picked by what is running
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;
  logic [1:0]         r_idx, c_idx, jj;
  logic [4:0]         cidx;

  assign r_idx = cmd_i.clip_idx[3:2];
  assign c_idx = cmd_i.clip_idx[1:0];
  assign jj    = cmd_i.j_idx;
  assign cidx  = {cmd_i.plane_idx, 2'b00} + {3'b000, jj};

  always_comb begin
    ma = proj_q[{r_idx, cmd_i.k_idx}];
    mb = view_q[{cmd_i.k_idx, c_idx}];
    if (cmd_i.nsq_step) begin
      ma = raw_q[jj];
      mb = raw_q[jj];
    end else if (cmd_i.dist_step) begin
      ma = coef_q[cidx];
      case (jj)
        2'd0:    mb = x_q;
        2'd1:    mb = y_q;
        default: mb = z_q;
      endcase
    end
  end

  assign prod    = ma * mb;
  assign prod_sh = 48'(prod >>> FracBits);

  // raw plane row formed from the clip rows
  logic signed [32:0] rsum [4];
  logic [1:0]         prow;
  assign prow = plane_row(cmd_i.plane_idx);
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (plane_add(cmd_i.plane_idx))
        rsum[j] = 33'(clip_q[Row3Base + j]) + 33'(clip_q[{prow, 2'(j)}]);
      else
        rsum[j] = 33'(clip_q[Row3Base + j]) - 33'(clip_q[{prow, 2'(j)}]);
    end
  end

  // one bit pair of the square root per step
  logic [63:0] s_try;
  assign s_try = sroot_q + sbit_q;

  // restoring divide of |raw| << frac by len, one quotient bit per step
  logic [32:0] dr_sh;
  logic [31:0] raw_abs;
  logic signed [31:0] raw_j;
  logic [1:0]  dj;
  // while one coefficient is stored the divide of the next one of the same plane starts
  assign dj      = cmd_i.coef_store ? jj + 2'd1 : jj;
  assign raw_j   = raw_q[dj];
  assign raw_abs = raw_j[31] ? 32'(-raw_j) : 32'(raw_j);
  assign dr_sh   = {drem_q[31:0], dnum_q[63]};

  logic signed [65:0] qsigned;
  assign qsigned = dneg_q ? -$signed({2'b00, dquo_q}) : $signed({2'b00, dquo_q});

  logic signed [66:0] rad_neg;
  logic signed [66:0] near_sum;
  assign rad_neg  = -$signed({36'd0, rad_q});
  assign near_sum = dist_q + $signed({36'd0, rad_q});
  assign sts_o.culled = (act_q == ACT_SPHERE) ? (dist_q <= rad_neg) : (dist_q <= 67'sd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q <= action_i;
      idx_q <= elem_index_i;
      val_q <= elem_value_i;
      x_q   <= point_x_i;
      y_q   <= point_y_i;
      z_q   <= point_z_i;
      rad_q <= sphere_radius_i;
    end
    if (cmd_i.mac_clear || cmd_i.clip_store) acc_q <= '0;
    if (cmd_i.mac_step && !cmd_i.clip_store) acc_q <= acc_q + 66'(prod_sh);
    if (cmd_i.clip_store) clip_q[cmd_i.clip_idx] <= sat32(acc_q + 66'(prod_sh));
    if (cmd_i.raw_form) begin
      for (int j = 0; j < 4; j++) raw_q[j] <= sat32(66'(rsum[j]));
      nsq_q <= '0;
    end
    if (cmd_i.nsq_step) nsq_q <= nsq_q + 64'(prod);
    if (cmd_i.sqrt_start) begin
      srem_q  <= nsq_q + 64'(prod);
      sroot_q <= '0;
      sbit_q  <= 64'h4000_0000_0000_0000;
    end
    if (cmd_i.sqrt_step) begin
      if (srem_q >= s_try) begin
        srem_q  <= srem_q - s_try;
        sroot_q <= (sroot_q >> 1) + sbit_q;
      end else begin
        sroot_q <= sroot_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.div_start) begin
      if (cmd_i.sqrt_step) len_q <= (srem_q >= s_try) ? 32'((sroot_q >> 1) + sbit_q)
                                                       : 32'(sroot_q >> 1);
      dnum_q <= 64'(raw_abs) << FracBits;
      dneg_q <= raw_j[31];
      drem_q <= '0;
      dquo_q <= '0;
    end
    if (cmd_i.div_step) begin
      dnum_q <= dnum_q << 1;
      if (dr_sh >= {1'b0, len_q}) begin
        drem_q <= dr_sh - {1'b0, len_q};
        dquo_q <= {dquo_q[62:0], 1'b1};
      end else begin
        drem_q <= dr_sh;
        dquo_q <= {dquo_q[62:0], 1'b0};
      end
    end
    if (cmd_i.res_clear) begin
      dist_q <= '0;
      near_q <= '0;
    end
    if (cmd_i.dist_step) begin
      if (jj == 2'd3) dist_q <= dist_q + 67'(coef_q[cidx]);
      else            dist_q <= dist_q + 67'(prod_sh);
    end
    if (cmd_i.dist_eval && !cmd_i.res_finish) dist_q <= '0;
    if (cmd_i.res_finish)
      near_q <= (!sts_o.culled && act_q == ACT_SPHERE) ? sat32(66'(near_sum)) : '0;
  end

  // stores and flags with defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        proj_q[i] <= '0;
        view_q[i] <= '0;
      end
      for (int i = 0; i < 24; i++) coef_q[i] <= '0;
      degen_q  <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      if (cmd_i.wr_proj) proj_q[idx_q] <= val_q;
      if (cmd_i.wr_view) view_q[idx_q] <= val_q;
      if (cmd_i.degen_clear) degen_q <= 1'b0;
      if (cmd_i.coef_store) begin
        coef_q[cidx] <= (len_q == '0) ? 32'sd0 : sat32(qsigned);
        if (len_q == '0) degen_q <= 1'b1;
      end
      if (cmd_i.res_clear) inside_q <= 1'b0;
      if (cmd_i.res_finish) inside_q <= !sts_o.culled;
    end
  end

  assign inside_res_o       = inside_q;
  assign near_distance_o    = near_q;
  assign plane_degenerate_o = degen_q;

endmodule

// ===== rtl/frustum_plane_culling_top.sv =====
// frustum_plane_culling_top: frustum plane extraction and point/sphere culling
// queries test the planes in order and stop at the first plane that culls the item
// extraction: 64 mac steps, then per plane 4 + 32 root steps + 4 x 64 divide steps
// one item at a time, set by the shared multiplier and the serial root/divider
// reset: asynchronous active low, clears the matrix and plane stores and the flags
module frustum_plane_culling_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [3:0]         elem_index_i,
  input  logic signed [31:0] elem_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [30:0]        sphere_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               inside_res_o,
  output logic signed [31:0] near_distance_o,
  output logic               plane_degenerate_o
);
  import fpc_pkg::*;

  fpc_cmd_t cmd;
  fpc_sts_t sts;

  fpc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i,
    .out_valid_o, .out_ready_i, .sts_i(sts), .cmd_o(cmd)
  );

  fpc_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .action_i, .elem_index_i,
    .elem_value_i, .point_x_i, .point_y_i, .point_z_i, .sphere_radius_i,
    .inside_res_o, .near_distance_o, .plane_degenerate_o
  );

endmodule
